FILE: rtl/clst_pkg.sv
// shared types and codes of the consensus log slot table
package clst_pkg;

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_COMMIT       = 3'd1,
        OP_EXECUTE      = 3'd2,
        OP_COMMIT_UNTIL = 3'd3,
        OP_TRIM_UNTIL   = 3'd4,
        OP_POLL         = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_STALE     = 3'd1,
        ST_ABSENT    = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_FULL      = 3'd4,
        ST_VIOLATION = 3'd5,
        ST_MISMATCH  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PH_PROGRESS  = 2'd0,
        PH_COMMITTED = 2'd1,
        PH_EXECUTED  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_RESP = 2'd2
    } t_state;

endpackage

FILE: rtl/clst_if.sv
// request and response channel interfaces of the slot table
interface clst_req_if #(
    parameter int INDEX_BITS   = 32,
    parameter int BALLOT_BITS  = 32,
    parameter int COMMAND_BITS = 32
);
    logic                    valid;
    logic                    ready;
    logic [2:0]              cmd;
    logic [INDEX_BITS-1:0]   log_index;
    logic [BALLOT_BITS-1:0]  ballot;
    logic [31:0]             client_id;
    logic [COMMAND_BITS-1:0] command_word;

    modport source (output valid, cmd, log_index, ballot, client_id, command_word,
                    input ready);
    modport sink (input valid, cmd, log_index, ballot, client_id, command_word,
                  output ready);
endinterface

interface clst_rsp_if #(
    parameter int INDEX_BITS   = 32,
    parameter int COMMAND_BITS = 32
);
    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic                    inserted;
    logic [INDEX_BITS-1:0]   exec_index;
    logic [31:0]             exec_client;
    logic [COMMAND_BITS-1:0] exec_command;
    logic [INDEX_BITS-1:0]   executed_upto;
    logic [INDEX_BITS-1:0]   highest_index;

    modport source (output valid, status, inserted, exec_index, exec_client,
                    exec_command, executed_upto, highest_index, input ready);
    modport sink (input valid, status, inserted, exec_index, exec_client,
                  exec_command, executed_upto, highest_index, output ready);
endinterface

FILE: rtl/consensus_log_slot_table_core.sv
// replicated log slot table: ring of slot cells with a single head processor
// requests settled at decode go straight to the response register, others wait for the target slot to reach the head
// commit-until and trim-until then walk on slot by slot (up to LOG_DEPTH slots)
// throughput: one request at a time, set by the ring rotation reaching the target slot
// reset: all slot valid bits, done, trimmed and top index cleared
module consensus_log_slot_table_core
    import clst_pkg::*;
#(
    parameter int LOG_DEPTH    = 64,
    parameter int INDEX_BITS   = 32,
    parameter int BALLOT_BITS  = 32,
    parameter int COMMAND_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clst_req_if.sink   i_req,
    clst_rsp_if.source o_rsp
);
    localparam int SLOT_BITS = $clog2(LOG_DEPTH);
    localparam int CW        = (INDEX_BITS > SLOT_BITS + 1) ? INDEX_BITS : SLOT_BITS + 2;
    localparam int DATA_BITS = 2 + BALLOT_BITS + 32 + COMMAND_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(LOG_DEPTH - 1);
    localparam logic [CW-1:0]        DEPTH_CW  = CW'(LOG_DEPTH);
    localparam logic [SLOT_BITS:0]   DEPTH_SW  = (SLOT_BITS + 1)'(LOG_DEPTH);

    typedef struct packed {
        t_phase                  phase;
        logic [BALLOT_BITS-1:0]  ballot;
        logic [31:0]             client;
        logic [COMMAND_BITS-1:0] command;
    } t_slot;

    // decision taken when a request is accepted
    typedef struct packed {
        t_op                   op;
        logic                  scan;
        t_status               status;
        logic [INDEX_BITS-1:0] cur;
        logic [SLOT_BITS-1:0]  slot;
    } t_dec;

    // result of processing the slot at the head cell
    typedef struct packed {
        logic    fin;
        t_status status;
        logic    ins;
        logic    exec;
        logic    top_upd;
        logic    trim_upd;
        logic    step;
    } t_step;

    // index inside the storable window trimmed+1 .. trimmed+LOG_DEPTH
    function automatic logic f_in_window(input logic [INDEX_BITS-1:0] idx,
                                         input logic [INDEX_BITS-1:0] trim);
        logic [INDEX_BITS-1:0] diff;
        diff = idx - trim;
        return (idx > trim) && (CW'(diff) <= DEPTH_CW);
    endfunction

    // slot of an in-window index, from the slot of the trim point
    function automatic logic [SLOT_BITS-1:0] f_slot(input logic [SLOT_BITS-1:0]  tslot,
                                                     input logic [INDEX_BITS-1:0] idx,
                                                     input logic [INDEX_BITS-1:0] trim);
        logic [INDEX_BITS-1:0] diff;
        logic [SLOT_BITS:0]    sum;
        diff = idx - trim;
        sum  = {1'b0, tslot} + diff[SLOT_BITS:0];
        if (sum >= DEPTH_SW) begin
            sum = sum - DEPTH_SW;
        end
        return sum[SLOT_BITS-1:0];
    endfunction

    function automatic logic [SLOT_BITS-1:0] f_inc(input logic [SLOT_BITS-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    // control state
    t_state r_state, n_state;
    t_op    r_op;
    logic [INDEX_BITS-1:0]   r_cur, r_lim;
    logic [BALLOT_BITS-1:0]  r_bal;
    logic [31:0]             r_cli;
    logic [COMMAND_BITS-1:0] r_cmdw;
    logic [SLOT_BITS-1:0]    r_slot, r_head, r_trim_slot;
    logic [INDEX_BITS-1:0]   r_done, r_trim, r_top;

    // pending result
    t_status                 r_st;
    logic                    r_ins;
    logic [INDEX_BITS-1:0]   r_exi;
    logic [31:0]             r_exc;
    logic [COMMAND_BITS-1:0] r_exw;

    // output register
    logic                    r_out_valid;
    t_status                 r_out_st;
    logic                    r_out_ins;
    logic [INDEX_BITS-1:0]   r_out_exi, r_out_done, r_out_top;
    logic [31:0]             r_out_exc;
    logic [COMMAND_BITS-1:0] r_out_exw;

    logic  w_acc, w_hit, w_load;
    t_dec  w_dec;
    t_step w_step;

    // ring of cells: cell 0 is the head, the head writes back into the last cell
    logic                 w_cell_v [LOG_DEPTH];
    logic [DATA_BITS-1:0] w_cell_d [LOG_DEPTH];
    logic                 w_wb_v;
    t_slot                w_wb;
    t_slot                w_head;
    logic                 w_head_v;

    for (genvar j = 0; j < LOG_DEPTH; j++) begin : g_ring
        if (j == LOG_DEPTH - 1) begin : g_tail
            clst_cell #(.DATA_BITS(DATA_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_valid(w_wb_v),
                .i_data (w_wb),
                .o_valid(w_cell_v[j]),
                .o_data (w_cell_d[j])
            );
        end else begin : g_body
            clst_cell #(.DATA_BITS(DATA_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_valid(w_cell_v[j+1]),
                .i_data (w_cell_d[j+1]),
                .o_valid(w_cell_v[j]),
                .o_data (w_cell_d[j])
            );
        end
    end

    assign w_head_v = w_cell_v[0];
    assign w_head   = t_slot'(w_cell_d[0]);

    assign w_acc = i_req.valid && i_req.ready;
    assign w_hit = (r_state == S_SCAN) && (r_head == r_slot);

    // request decode: settle what needs no slot, else aim at the target slot
    always_comb begin
        logic [INDEX_BITS-1:0] nx_done;
        nx_done      = r_done + 1'b1;
        w_dec        = '0;
        w_dec.status = ST_DONE;
        w_dec.cur    = i_req.log_index;
        w_dec.slot   = f_slot(r_trim_slot, i_req.log_index, r_trim);
        unique case (i_req.cmd)
            OP_APPEND:       w_dec.op = OP_APPEND;
            OP_COMMIT:       w_dec.op = OP_COMMIT;
            OP_EXECUTE:      w_dec.op = OP_EXECUTE;
            OP_COMMIT_UNTIL: w_dec.op = OP_COMMIT_UNTIL;
            OP_TRIM_UNTIL:   w_dec.op = OP_TRIM_UNTIL;
            default:         w_dec.op = OP_POLL;
        endcase
        case (w_dec.op)
            OP_APPEND: begin
                if (i_req.log_index <= r_trim) begin
                    w_dec.status = ST_STALE;
                end else if (!f_in_window(i_req.log_index, r_trim)) begin
                    w_dec.status = ST_FULL;
                end else begin
                    w_dec.scan = 1'b1;
                end
            end
            OP_COMMIT: begin
                if (!f_in_window(i_req.log_index, r_trim)) begin
                    w_dec.status = ST_ABSENT;
                end else begin
                    w_dec.scan = 1'b1;
                end
            end
            OP_EXECUTE: begin
                w_dec.cur  = nx_done;
                w_dec.slot = f_slot(r_trim_slot, nx_done, r_trim);
                if (nx_done == '0 || !f_in_window(nx_done, r_trim)) begin
                    w_dec.status = ST_ABSENT;
                end else begin
                    w_dec.scan = 1'b1;
                end
            end
            OP_COMMIT_UNTIL: begin
                w_dec.cur  = nx_done;
                w_dec.slot = f_slot(r_trim_slot, nx_done, r_trim);
                w_dec.scan = (r_done < i_req.log_index) && f_in_window(nx_done, r_trim);
            end
            OP_TRIM_UNTIL: begin
                w_dec.cur  = r_trim + 1'b1;
                w_dec.slot = f_inc(r_trim_slot);
                w_dec.scan = r_trim < i_req.log_index;
            end
            default: begin
                w_dec.scan = 1'b0;
            end
        endcase
    end

    // head processing: one slot per cycle, written back into the ring tail
    always_comb begin
        w_wb_v        = w_head_v;
        w_wb          = w_head;
        w_step        = '0;
        w_step.status = r_st;
        if (w_hit) begin
            case (r_op)
                OP_APPEND: begin
                    w_step.fin = 1'b1;
                    if (!w_head_v) begin
                        w_wb_v         = 1'b1;
                        w_wb           = {PH_PROGRESS, r_bal, r_cli, r_cmdw};
                        w_step.ins     = 1'b1;
                        w_step.top_upd = r_cur > r_top;
                    end else if (w_head.phase != PH_PROGRESS) begin
                        if (w_head.command != r_cmdw) begin
                            w_step.status = ST_MISMATCH;
                        end
                    end else if (r_bal > w_head.ballot) begin
                        w_wb = {PH_PROGRESS, r_bal, r_cli, r_cmdw};
                    end else if (r_bal == w_head.ballot && w_head.command != r_cmdw) begin
                        w_step.status = ST_MISMATCH;
                    end
                end
                OP_COMMIT: begin
                    w_step.fin = 1'b1;
                    if (!w_head_v) begin
                        w_step.status = ST_ABSENT;
                    end else if (w_head.phase == PH_PROGRESS) begin
                        w_wb.phase = PH_COMMITTED;
                    end
                end
                OP_EXECUTE: begin
                    w_step.fin = 1'b1;
                    if (!w_head_v) begin
                        w_step.status = ST_ABSENT;
                    end else if (w_head.phase != PH_COMMITTED) begin
                        w_step.status = ST_NOT_READY;
                    end else begin
                        w_wb.phase  = PH_EXECUTED;
                        w_step.exec = 1'b1;
                    end
                end
                OP_COMMIT_UNTIL: begin
                    // missing entry ends the walk quietly
                    if (!f_in_window(r_cur, r_trim) || !w_head_v) begin
                        w_step.fin = 1'b1;
                    end else if (r_bal < w_head.ballot) begin
                        w_step.fin    = 1'b1;
                        w_step.status = ST_VIOLATION;
                    end else begin
                        if (w_head.ballot == r_bal && w_head.phase == PH_PROGRESS) begin
                            w_wb.phase = PH_COMMITTED;
                        end
                        w_step.fin  = r_cur == r_lim;
                        w_step.step = 1'b1;
                    end
                end
                OP_TRIM_UNTIL: begin
                    if (!w_head_v || w_head.phase != PH_EXECUTED) begin
                        w_step.fin    = 1'b1;
                        w_step.status = ST_VIOLATION;
                    end else begin
                        w_wb_v          = 1'b0;
                        w_step.trim_upd = 1'b1;
                        w_step.fin      = r_cur == r_lim;
                        w_step.step     = 1'b1;
                    end
                end
                default: begin
                    w_step.fin = 1'b1;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = w_dec.scan ? S_SCAN : S_RESP;
                end
            end
            S_SCAN: begin
                if (w_step.fin) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        w_load      = (r_state == S_RESP) && (!r_out_valid || o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_done      <= '0;
            r_trim      <= '0;
            r_trim_slot <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= f_inc(r_head);
            if (w_step.exec) begin
                r_done <= r_cur;
            end
            if (w_step.top_upd) begin
                r_top <= r_cur;
            end
            if (w_step.trim_upd) begin
                r_trim      <= r_cur;
                r_trim_slot <= r_slot;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op   <= w_dec.op;
            r_cur  <= w_dec.cur;
            r_slot <= w_dec.slot;
            r_lim  <= i_req.log_index;
            r_bal  <= i_req.ballot;
            r_cli  <= i_req.client_id;
            r_cmdw <= i_req.command_word;
            r_st   <= w_dec.status;
            r_ins  <= 1'b0;
            r_exi  <= '0;
            r_exc  <= '0;
            r_exw  <= '0;
        end else if (w_hit) begin
            r_st <= w_step.status;
            if (w_step.ins) begin
                r_ins <= 1'b1;
            end
            if (w_step.exec) begin
                r_exi <= r_cur;
                r_exc <= w_head.client;
                r_exw <= w_head.command;
            end
            if (w_step.step) begin
                r_cur  <= r_cur + 1'b1;
                r_slot <= f_inc(r_slot);
            end
        end
        if (w_load) begin
            r_out_st   <= r_st;
            r_out_ins  <= r_ins;
            r_out_exi  <= r_exi;
            r_out_exc  <= r_exc;
            r_out_exw  <= r_exw;
            r_out_done <= r_done;
            r_out_top  <= r_top;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_st;
    assign o_rsp.inserted      = r_out_ins;
    assign o_rsp.exec_index    = r_out_exi;
    assign o_rsp.exec_client   = r_out_exc;
    assign o_rsp.exec_command  = r_out_exw;
    assign o_rsp.executed_upto = r_out_done;
    assign o_rsp.highest_index = r_out_top;

    // only executed entries are ever freed
    a_trim_le_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trim <= r_done)
        else $error("trim point passed executed point");

    // an insert is always a clean append
    a_insert_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.inserted) |-> (o_rsp.status == ST_DONE))
        else $error("insert reported with failure status");

    // failed requests carry no executed entry
    a_fail_no_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_DONE) |-> (o_rsp.exec_index == '0))
        else $error("executed entry on failed request");

    // a scan never runs while a new request is taken
    a_scan_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> !w_acc)
        else $error("request taken during scan");
endmodule

FILE: rtl/clst_cell.sv
// one slot cell of the rotating ring
module clst_cell #(
    parameter int DATA_BITS = 98
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data
);
    logic                 r_valid;
    logic [DATA_BITS-1:0] r_data;

    // valid bit cleared at reset, payload free running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= i_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
